FILE: hw/rtl/hse_pkg.sv
// Shared types and constants for the Huffman stream encoder.
// Used by hse_front, hse_queue, hse_back and huffman_stream_encoder.
package hse_pkg;

  localparam int CODE_W      = 24;  // code word field width
  localparam int LEN_W       = 5;   // code length field width
  localparam int BYTE_W      = 8;
  localparam int VBITS_W     = 4;
  localparam int ENTRY_W     = CODE_W + LEN_W;
  localparam int IN_TDATA_W  = 40;  // symbol, code_word, code_length, padded
  localparam int OUT_TDATA_W = 16;  // out_byte, valid_bits, padded
  localparam int GRP_BYTES   = 3;   // at most 7 pending + 24 new bits -> 3 bytes
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  // Bytes produced by one request, earliest in bytes[0].
  typedef struct packed {
    logic [1:0]                      n;      // 1..3 bytes
    logic [GRP_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [VBITS_W-1:0]              vbits;  // valid bits of the final byte
  } group_t;

endpackage

FILE: hw/rtl/hse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/hse_front.sv
// Front end: accepts requests, keeps the code table, packs code bits into bytes.
// Depends on hse_pkg and hse_ram.
module hse_front #(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_CODE_LEN  = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hse_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [1:0]                     in_tuser,
  output logic                           push_valid,
  output hse_pkg::group_t                push_data,
  input  logic                           push_ready
);

  localparam int AW = $clog2(ALPHABET_SIZE);

  hse_pkg::cmd_t                cmd;
  logic [hse_pkg::BYTE_W-1:0]   sym;
  logic [hse_pkg::CODE_W-1:0]   word;
  logic [hse_pkg::LEN_W-1:0]    len;
  logic [hse_pkg::LEN_W-1:0]    len_sat;
  logic [hse_pkg::CODE_W-1:0]   code_la;
  logic                         sym_ok;
  logic                         accept;
  logic                         we;
  logic [AW-1:0]                addr;
  logic [hse_pkg::ENTRY_W-1:0]  rdata;

  logic [ALPHABET_SIZE-1:0]     vld_r, vld_nxt;
  logic                         s1_valid_r, s1_valid_nxt;
  hse_pkg::cmd_t                s1_cmd_r;
  logic                         s1_ok_r;
  logic [hse_pkg::BYTE_W-1:0]   pend_r, pend_nxt;
  logic [2:0]                   cnt_r, cnt_nxt;
  logic                         s2_go;

  assign cmd  = hse_pkg::cmd_t'(in_tuser);
  assign sym  = in_tdata[7:0];
  assign word = in_tdata[31:8];
  assign len  = in_tdata[36:32];
  assign addr = sym[AW-1:0];

  assign sym_ok  = {1'b0, sym} < 9'(ALPHABET_SIZE);
  assign len_sat = (len > hse_pkg::LEN_W'(MAX_CODE_LEN)) ? hse_pkg::LEN_W'(MAX_CODE_LEN) : len;
  // Left-align the code; bits above the length fall off the top.
  assign code_la = word << (hse_pkg::LEN_W'(hse_pkg::CODE_W) - len_sat);

  assign s2_go     = s1_valid_r && push_ready;
  assign in_tready = !s1_valid_r || s2_go;
  assign accept    = in_tvalid && in_tready;
  assign we        = accept && (cmd == hse_pkg::CMD_LOAD) && sym_ok;

  hse_ram #(
    .WIDTH(hse_pkg::ENTRY_W),
    .DEPTH(ALPHABET_SIZE)
  ) u_code_ram (
    .clk  (clk),
    .we   (we),
    .waddr(addr),
    .wdata({len_sat, code_la}),
    .re   (accept),
    .raddr(addr),
    .rdata(rdata)
  );

  // Packing stage
  always_comb begin
    logic [hse_pkg::LEN_W-1:0]  clen;
    logic [hse_pkg::CODE_W-1:0] code;
    logic [31:0]                comb_w;
    logic [5:0]                 total;
    logic [1:0]                 nb;
    logic                       hit;

    clen   = rdata[hse_pkg::ENTRY_W-1:hse_pkg::CODE_W];
    code   = rdata[hse_pkg::CODE_W-1:0];
    hit    = s1_ok_r && (clen != '0);
    comb_w = {pend_r, 24'd0} | ({code, 8'd0} >> cnt_r);
    total  = 6'(cnt_r) + 6'(clen);
    nb     = total[4:3];

    pend_nxt   = pend_r;
    cnt_nxt    = cnt_r;
    push_valid = 1'b0;
    push_data.n     = nb;
    push_data.bytes = {comb_w[15:8], comb_w[23:16], comb_w[31:24]};
    push_data.vbits = 4'd8;

    if (s1_valid_r) begin
      unique case (s1_cmd_r)
        hse_pkg::CMD_ENCODE: begin
          if (hit) begin
            push_valid = (nb != 2'd0);
            cnt_nxt    = total[2:0];
            unique case (nb)
              2'd0: pend_nxt = comb_w[31:24];
              2'd1: pend_nxt = comb_w[23:16];
              2'd2: pend_nxt = comb_w[15:8];
              2'd3: pend_nxt = comb_w[7:0];
            endcase
          end
        end
        hse_pkg::CMD_FLUSH: begin
          push_valid      = (cnt_r != 3'd0);
          push_data.n     = 2'd1;
          push_data.bytes = {16'd0, pend_r};
          push_data.vbits = {1'b0, cnt_r};
          pend_nxt        = '0;
          cnt_nxt         = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (we) begin
      vld_nxt[addr] = 1'b1;
    end
    s1_valid_nxt = accept ? 1'b1 : (s2_go ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      s1_valid_r <= 1'b0;
      pend_r     <= '0;
      cnt_r      <= '0;
    end else begin
      vld_r      <= vld_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s2_go) begin
        pend_r <= pend_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r <= cmd;
      s1_ok_r  <= sym_ok && vld_r[addr];
    end
  end

endmodule

FILE: hw/rtl/hse_queue.sv
// Short queue of byte groups between the packer and the serializer.
// Depends on hse_pkg.
module hse_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  hse_pkg::group_t push_data,
  output logic            push_ready,
  output logic            head_valid,
  output hse_pkg::group_t head,
  input  logic            pop
);

  hse_pkg::group_t                 ent_r [hse_pkg::QDEPTH];
  logic [hse_pkg::QPTR_W-1:0]      wptr_r, wptr_nxt;
  logic [hse_pkg::QPTR_W-1:0]      rptr_r, rptr_nxt;
  logic [hse_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (cnt_r != hse_pkg::QCNT_W'(hse_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = ent_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + hse_pkg::QCNT_W'(do_push) - hse_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/hse_back.sv
// Back end: walks each queued group one byte a cycle into the output register while out_tready allows.
// Depends on hse_pkg.
module hse_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  hse_pkg::group_t                 head,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hse_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  logic [1:0]                   idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [hse_pkg::BYTE_W-1:0]   byte_r;
  logic [hse_pkg::VBITS_W-1:0]  vbits_r;
  logic                         last_r;
  logic                         load;
  logic                         is_last;

  assign load    = head_valid && (!out_valid_r || out_tready);
  assign is_last = (idx_r == head.n - 2'd1);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= head.bytes[idx_r];
      vbits_r <= is_last ? head.vbits : 4'd8;
      last_r  <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, vbits_r, byte_r};
  assign out_tlast  = last_r;

endmodule

FILE: hw/rtl/huffman_stream_encoder.sv
// Huffman stream encoder: code table load, bit packing, flush.
// Path: code RAM read register, packer, group queue, then the out_* register.
// Throughput: one request per cycle while the queue has room; the output moves one byte
// per cycle while out_tready is high (4-group queue absorbs bursts).
// Reset: synchronous; clears the length-table valid bits at once, no clearing pass.
// The code table itself holds no reset value; its read data is used only for loaded entries.
module huffman_stream_encoder #(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_CODE_LEN  = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] symbol, [31:8] code_word, [36:32] code_length, [39:37] zero
  input  logic [hse_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] cmd
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] out_byte, [11:8] valid_bits, [15:12] zero
  output logic [hse_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  logic            push_valid;
  logic            push_ready;
  hse_pkg::group_t push_data;
  logic            head_valid;
  hse_pkg::group_t head;
  logic            pop;

  hse_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push_valid(push_valid),
    .push_data (push_data),
    .push_ready(push_ready)
  );

  hse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_data (push_data),
    .push_ready(push_ready),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  hse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
